[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for concurrent assertions in the union-find unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GSUF_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define GSUF_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define GSUF_ASSERT(name, clk, rst, prop)
`define GSUF_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

[sv/gsuf_pkg.sv]
// ----------------------------------------------------------------------------
// Union-find package
// Types, codes and constants shared by the segmentation union-find unit.
// ----------------------------------------------------------------------------
package gsuf_pkg;

  localparam int VERTEX_W = 16;
  localparam int WEIGHT_W = 24;
  localparam int SIZE_W = 17;
  localparam int RANK_W = 5;
  localparam int THR_W = 25;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_CNT_W = 5;
  localparam int DEFAULT_MAX_VERTICES = 65536;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_EDGE = 2'd1;
  localparam logic [1:0] OP_FIND = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_NUM_VERTICES = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MERGE_CONSTANT = 1'd1;

  localparam logic [SIZE_W-1:0] NUM_VERTICES_RESET = 17'd65536;
  localparam logic [WEIGHT_W-1:0] MERGE_CONSTANT_RESET = 24'd76800;
  localparam logic [RANK_W-1:0] RANK_MAX = 5'd31;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_BIT = 5'd23;

  typedef struct packed {
    logic [1:0] op;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
    logic [WEIGHT_W-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] root_a;
    logic [VERTEX_W-1:0] root_b;
    logic merged;
    logic [VERTEX_W-1:0] new_root;
    logic [SIZE_W-1:0] set_size;
    logic [SIZE_W-1:0] components;
    logic status;
  } out_item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [SIZE_W-1:0] size;
    logic [THR_W-1:0] thr;
  } attr_t;

  typedef struct packed {
    logic accept;
    logic clr_init;
    logic clr_step;
    logic walk_init_a;
    logic walk_init_b;
    logic walk_adv;
    logic walk_wb_a;
    logic walk_wb_b;
    logic rd_attr_b;
    logic lat_a;
    logic lat_b;
    logic eval;
    logic div_step;
    logic merge;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic range_ok;
    logic n_zero;
    logic clr_last;
    logic walk_hit;
    logic walk_limit;
    logic merge_ok;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

[sv/gsuf_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, write enable, registered read data.
// ----------------------------------------------------------------------------
module gsuf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[sv/gsuf_dp.sv]
// ----------------------------------------------------------------------------
// Union-find datapath
// Vertex stores, root walk, merge arithmetic, serial divider and result.
// ----------------------------------------------------------------------------
module gsuf_dp #(
  parameter int MAX_VERTICES = gsuf_pkg::DEFAULT_MAX_VERTICES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gsuf_pkg::in_item_t                  in_data,
  input  logic                                cfg_valid,
  input  logic [gsuf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [gsuf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  gsuf_pkg::cmd_t                      cmd,
  output gsuf_pkg::sts_t                      sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gsuf_pkg::out_item_t                 out_data
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int STEP_W = AW + 1;
  localparam int VW = gsuf_pkg::VERTEX_W;
  localparam int SW = gsuf_pkg::SIZE_W;

  logic [SW-1:0] vertex_total;
  logic [gsuf_pkg::WEIGHT_W-1:0] merge_constant;
  gsuf_pkg::in_item_t item;
  logic [VW-1:0] cur;
  logic [STEP_W-1:0] steps;
  logic [VW-1:0] ra;
  logic [VW-1:0] rb;
  gsuf_pkg::attr_t attr_a;
  gsuf_pkg::attr_t attr_b;
  logic [VW-1:0] top;
  logic [VW-1:0] sub;
  logic [gsuf_pkg::RANK_W-1:0] rank_new;
  logic [SW-1:0] total;
  logic [gsuf_pkg::WEIGHT_W-1:0] quo;
  logic [SW:0] rem;
  logic [gsuf_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [SW-1:0] clr_idx;
  logic [SW-1:0] comp_count;
  logic merged;

  logic [SW-1:0] n;
  logic [VW-1:0] p_rd;
  gsuf_pkg::attr_t a_rd;
  logic [AW-1:0] p_addr;
  logic [AW-1:0] a_addr;
  logic p_we;
  logic a_we;
  logic [VW-1:0] p_wdata;
  gsuf_pkg::attr_t a_wdata;
  logic a_top;
  logic [SW:0] size_sum;
  logic [SW:0] rem_sh;
  logic [SW:0] divisor;
  logic div_ge;
  logic [gsuf_pkg::THR_W-1:0] thr_new;
  logic [gsuf_pkg::THR_W-1:0] weight_ext;
  gsuf_pkg::out_item_t res;

  assign n = (32'(vertex_total) < MAX_VERTICES) ? vertex_total : SW'(MAX_VERTICES);
  assign weight_ext = gsuf_pkg::THR_W'(item.edge_weight);

  assign sts.op = item.op;
  assign sts.range_ok = ({1'b0, item.vertex_a} < n) &&
                        ((item.op != gsuf_pkg::OP_EDGE) || ({1'b0, item.vertex_b} < n));
  assign sts.n_zero = (n == '0);
  assign sts.clr_last = (clr_idx == (n - SW'(1)));
  assign sts.walk_hit = (p_rd == cur) || (32'(p_rd) >= MAX_VERTICES);
  assign sts.walk_limit = (steps == STEP_W'(MAX_VERTICES - 1));
  assign sts.merge_ok = (ra != rb) && (weight_ext <= attr_a.thr) && (weight_ext <= attr_b.thr);
  assign sts.div_last = (div_cnt == '0);
  assign sts.out_free = !out_valid || out_ready;

  assign a_top = (attr_a.rank >= attr_b.rank);
  assign size_sum = {1'b0, attr_a.size} + {1'b0, attr_b.size};
  assign rem_sh = {rem[SW-1:0], quo[gsuf_pkg::WEIGHT_W-1]};
  assign divisor = {1'b0, (total == '0) ? SW'(1) : total};
  assign div_ge = (rem_sh >= divisor);
  assign thr_new = weight_ext + gsuf_pkg::THR_W'(quo);

  always_comb begin
    p_we = cmd.clr_step || cmd.walk_wb_a || cmd.walk_wb_b || cmd.merge;
    a_we = cmd.clr_step || cmd.merge;
    if (cmd.clr_step) begin
      p_addr = AW'(clr_idx);
      p_wdata = clr_idx[VW-1:0];
    end else if (cmd.walk_wb_a) begin
      p_addr = AW'(item.vertex_a);
      p_wdata = cur;
    end else if (cmd.walk_wb_b) begin
      p_addr = AW'(item.vertex_b);
      p_wdata = cur;
    end else if (cmd.merge) begin
      p_addr = AW'(sub);
      p_wdata = top;
    end else begin
      p_addr = AW'(cur);
      p_wdata = cur;
    end
    if (cmd.clr_step) begin
      a_addr = AW'(clr_idx);
      a_wdata.rank = '0;
      a_wdata.size = SW'(1);
      a_wdata.thr = gsuf_pkg::THR_W'(merge_constant);
    end else begin
      if (cmd.rd_attr_b) begin
        a_addr = AW'(rb);
      end else if (cmd.merge) begin
        a_addr = AW'(top);
      end else begin
        a_addr = AW'(ra);
      end
      a_wdata.rank = rank_new;
      a_wdata.size = total;
      a_wdata.thr = thr_new;
    end
  end

  gsuf_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTICES)
  ) u_parent_ram (
    .clk   (clk),
    .addr  (p_addr),
    .we    (p_we),
    .wdata (p_wdata),
    .rdata (p_rd)
  );

  gsuf_ram #(
    .WIDTH ($bits(gsuf_pkg::attr_t)),
    .DEPTH (MAX_VERTICES)
  ) u_attr_ram (
    .clk   (clk),
    .addr  (a_addr),
    .we    (a_we),
    .wdata (a_wdata),
    .rdata (a_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_total <= gsuf_pkg::NUM_VERTICES_RESET;
      merge_constant <= gsuf_pkg::MERGE_CONSTANT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gsuf_pkg::REG_NUM_VERTICES: vertex_total <= cfg_data[SW-1:0];
        gsuf_pkg::REG_MERGE_CONSTANT: merge_constant <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_init) begin
        comp_count <= n;
      end else if (cmd.merge && comp_count != '0) begin
        comp_count <= comp_count - SW'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= in_data;
      ra <= '0;
      rb <= '0;
      merged <= 1'b0;
    end
    if (cmd.clr_init) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + SW'(1);
    end
    if (cmd.walk_init_a) begin
      cur <= item.vertex_a;
      steps <= '0;
    end else if (cmd.walk_init_b) begin
      cur <= item.vertex_b;
      steps <= '0;
    end else if (cmd.walk_adv) begin
      cur <= p_rd;
      steps <= steps + STEP_W'(1);
    end
    if (cmd.walk_wb_a) begin
      ra <= cur;
    end
    if (cmd.walk_wb_b) begin
      rb <= cur;
    end
    if (cmd.lat_a) begin
      attr_a <= a_rd;
    end
    if (cmd.lat_b) begin
      attr_b <= a_rd;
    end
    if (cmd.eval) begin
      top <= a_top ? ra : rb;
      sub <= a_top ? rb : ra;
      if (!a_top) begin
        rank_new <= attr_b.rank;
      end else if (attr_a.rank == attr_b.rank && attr_a.rank != gsuf_pkg::RANK_MAX) begin
        rank_new <= attr_a.rank + gsuf_pkg::RANK_W'(1);
      end else begin
        rank_new <= attr_a.rank;
      end
      total <= size_sum[SW] ? '1 : size_sum[SW-1:0];
      quo <= merge_constant;
      rem <= '0;
      div_cnt <= gsuf_pkg::DIV_LAST_BIT;
    end else if (cmd.div_step) begin
      rem <= div_ge ? (rem_sh - divisor) : rem_sh;
      quo <= {quo[gsuf_pkg::WEIGHT_W-2:0], div_ge};
      div_cnt <= div_cnt - gsuf_pkg::DIV_CNT_W'(1);
    end
    if (cmd.merge) begin
      merged <= 1'b1;
    end
    if (cmd.load_out) begin
      out_data <= res;
    end
  end

  always_comb begin
    res = '0;
    res.components = comp_count;
    case (item.op) inside
      gsuf_pkg::OP_CLEAR: begin
        res.set_size = SW'(1);
      end
      gsuf_pkg::OP_EDGE, gsuf_pkg::OP_FIND: begin
        if (!sts.range_ok) begin
          res.status = 1'b1;
        end else begin
          res.root_a = ra;
          res.root_b = rb;
          res.merged = merged;
          res.new_root = merged ? top : ra;
          res.set_size = merged ? total : attr_a.size;
        end
      end
      default: ;
    endcase
  end

endmodule

[sv/gsuf_ctrl.sv]
// ----------------------------------------------------------------------------
// Union-find controller
// Sequences clear sweeps, root walks, merge decisions and the divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gsuf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gsuf_pkg::sts_t sts,
  output gsuf_pkg::cmd_t cmd
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'b0000_0000_0000_0001,
    S_DISP  = 16'b0000_0000_0000_0010,
    S_CLR   = 16'b0000_0000_0000_0100,
    S_WA_RD = 16'b0000_0000_0000_1000,
    S_WA_CK = 16'b0000_0000_0001_0000,
    S_WA_WB = 16'b0000_0000_0010_0000,
    S_WB_RD = 16'b0000_0000_0100_0000,
    S_WB_CK = 16'b0000_0000_1000_0000,
    S_WB_WB = 16'b0000_0001_0000_0000,
    S_AT_A  = 16'b0000_0010_0000_0000,
    S_AT_B  = 16'b0000_0100_0000_0000,
    S_AT_L  = 16'b0000_1000_0000_0000,
    S_EVAL  = 16'b0001_0000_0000_0000,
    S_DIV   = 16'b0010_0000_0000_0000,
    S_MERGE = 16'b0100_0000_0000_0000,
    S_DONE  = 16'b1000_0000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.op == gsuf_pkg::OP_CLEAR) begin
          cmd.clr_init = 1'b1;
          state_next = sts.n_zero ? S_DONE : S_CLR;
        end else if ((sts.op == gsuf_pkg::OP_EDGE || sts.op == gsuf_pkg::OP_FIND)
                     && sts.range_ok) begin
          cmd.walk_init_a = 1'b1;
          state_next = S_WA_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_DONE;
        end
      end
      S_WA_RD: state_next = S_WA_CK;
      S_WA_CK: begin
        if (sts.walk_hit) begin
          state_next = S_WA_WB;
        end else begin
          cmd.walk_adv = 1'b1;
          state_next = sts.walk_limit ? S_WA_WB : S_WA_RD;
        end
      end
      S_WA_WB: begin
        cmd.walk_wb_a = 1'b1;
        if (sts.op == gsuf_pkg::OP_EDGE) begin
          cmd.walk_init_b = 1'b1;
          state_next = S_WB_RD;
        end else begin
          state_next = S_AT_A;
        end
      end
      S_WB_RD: state_next = S_WB_CK;
      S_WB_CK: begin
        if (sts.walk_hit) begin
          state_next = S_WB_WB;
        end else begin
          cmd.walk_adv = 1'b1;
          state_next = sts.walk_limit ? S_WB_WB : S_WB_RD;
        end
      end
      S_WB_WB: begin
        cmd.walk_wb_b = 1'b1;
        state_next = S_AT_A;
      end
      S_AT_A: state_next = S_AT_B;
      S_AT_B: begin
        cmd.lat_a = 1'b1;
        cmd.rd_attr_b = 1'b1;
        state_next = S_AT_L;
      end
      S_AT_L: begin
        cmd.lat_b = 1'b1;
        state_next = (sts.op == gsuf_pkg::OP_EDGE) ? S_EVAL : S_DONE;
      end
      S_EVAL: begin
        if (sts.merge_ok) begin
          cmd.eval = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_MERGE;
        end
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `GSUF_ASSERT(a_load_needs_free_slot, clk, rst, cmd.load_out |-> sts.out_free)
  `GSUF_ASSERT(a_merge_after_divide, clk, rst, cmd.merge |-> $past(state == S_DIV))
  `GSUF_ASSERT(a_clear_write_alone, clk, rst, cmd.clr_step |-> !(cmd.walk_wb_a || cmd.walk_wb_b || cmd.merge))
  `GSUF_ASSERT(a_accept_when_idle, clk, rst, cmd.accept |=> state == S_DISP)

endmodule

[sv/graph_segment_union_find_unit.sv]
// An edge walks both vertices to their roots and, when the sets merge, runs the serial divider
// and then updates the stores; a find walks one vertex; a clear sweeps every active vertex.
// The unit takes one transaction at a time: in_ready is high only while the controller is idle.
// Reset clears control state and the component count and reloads the configuration registers with their defaults.
// The vertex stores are not cleared by reset; a clear operation initializes them.
// ----------------------------------------------------------------------------
// Graph segmentation union-find unit
// Disjoint-set store with union by rank and adaptive merge thresholds.
// ----------------------------------------------------------------------------
module graph_segment_union_find_unit #(
  parameter int MAX_VERTICES = gsuf_pkg::DEFAULT_MAX_VERTICES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  gsuf_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output gsuf_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gsuf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gsuf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  gsuf_pkg::cmd_t cmd;
  gsuf_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  gsuf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gsuf_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[bench/graph_segment_union_find_checker.sv]
// ----------------------------------------------------------------------------
// Union-find result checker
// Watches the configuration, input and output channels of the union-find
// unit, keeps its own disjoint-set store and compares every result.
// ----------------------------------------------------------------------------
module graph_segment_union_find_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  gsuf_pkg::in_item_t               in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  gsuf_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [gsuf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gsuf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               mismatches,
  output int                               outstanding
);
  import gsuf_pkg::*;

  localparam int MAXV = DEFAULT_MAX_VERTICES;

  logic [VERTEX_W-1:0] parent_mem [MAXV];
  logic [RANK_W-1:0]   rank_mem   [MAXV];
  logic [SIZE_W-1:0]   size_mem   [MAXV];
  logic [THR_W-1:0]    thr_mem    [MAXV];
  logic [SIZE_W-1:0]   set_count;
  logic [SIZE_W-1:0]   vertex_limit;
  logic [WEIGHT_W-1:0] seg_const;
  out_item_t           expected_results [$];

  function automatic logic [VERTEX_W-1:0] find_root(logic [VERTEX_W-1:0] v);
    logic [VERTEX_W-1:0] cur;
    int                  steps;
    cur = v;
    steps = 0;
    while (steps < MAXV && parent_mem[cur] != cur) begin
      cur = parent_mem[cur];
      steps++;
    end
    parent_mem[v] = cur;
    return cur;
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t           r;
    logic [17:0]         n;
    logic [17:0]         total;
    logic [VERTEX_W-1:0] top;
    logic [VERTEX_W-1:0] sub;
    r = '0;
    n = (vertex_limit > MAXV) ? 18'(MAXV) : 18'(vertex_limit);
    if (it.op == OP_CLEAR) begin
      for (int i = 0; i < n; i++) begin
        parent_mem[i] = i[VERTEX_W-1:0];
        rank_mem[i] = '0;
        size_mem[i] = SIZE_W'(1);
        thr_mem[i] = THR_W'(seg_const);
      end
      set_count = n[SIZE_W-1:0];
      r.set_size = SIZE_W'(1);
    end else if (it.op == OP_FIND) begin
      if (it.vertex_a >= n) begin
        r.status = 1'b1;
      end else begin
        r.root_a = find_root(it.vertex_a);
        r.new_root = r.root_a;
        r.set_size = size_mem[r.root_a];
      end
    end else if (it.op == OP_EDGE) begin
      if (it.vertex_a >= n || it.vertex_b >= n) begin
        r.status = 1'b1;
      end else begin
        r.root_a = find_root(it.vertex_a);
        r.root_b = find_root(it.vertex_b);
        r.new_root = r.root_a;
        if (r.root_a != r.root_b && it.edge_weight <= thr_mem[r.root_a]
            && it.edge_weight <= thr_mem[r.root_b]) begin
          if (rank_mem[r.root_a] >= rank_mem[r.root_b]) begin
            top = r.root_a;
            sub = r.root_b;
            if (rank_mem[top] == rank_mem[sub] && rank_mem[top] < RANK_MAX) begin
              rank_mem[top] = rank_mem[top] + RANK_W'(1);
            end
          end else begin
            top = r.root_b;
            sub = r.root_a;
          end
          parent_mem[sub] = top;
          total = 18'(size_mem[top]) + 18'(size_mem[sub]);
          if (total > 18'h1FFFF) total = 18'h1FFFF;
          size_mem[top] = total[SIZE_W-1:0];
          if (total == 18'd0) total = 18'd1;
          thr_mem[top] = THR_W'(it.edge_weight) + THR_W'(seg_const / total);
          if (set_count > 0) set_count = set_count - SIZE_W'(1);
          r.merged = 1'b1;
          r.new_root = top;
        end
        r.set_size = size_mem[r.new_root];
      end
    end
    r.components = set_count;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      set_count <= '0;
      vertex_limit <= NUM_VERTICES_RESET;
      seg_const <= MERGE_CONSTANT_RESET;
      expected_results.delete();
      mismatches <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NUM_VERTICES) vertex_limit <= cfg_data[SIZE_W-1:0];
        else if (cfg_index == REG_MERGE_CONSTANT) seg_const <= cfg_data;
      end
      if (in_valid && in_ready) expected_results.push_back(apply_item(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %p", out_data);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            if (mismatches < 10) begin
              $display("result mismatch: expected %p", want);
              $display("                 actual   %p", out_data);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

[bench/tb_graph_segment_union_find_unit.sv]
// ----------------------------------------------------------------------------
// Union-find unit testbench
// Drives clear, edge, find and reserved transactions under several idling and output-stall phases and
// configurations; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_graph_segment_union_find_unit;
  import gsuf_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     mismatches;
  int                     outstanding;
  int                     idle_pct = 0;
  int                     stall_pct = 0;
  int                     active_n;

  graph_segment_union_find_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  graph_segment_union_find_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #200000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic push_item(logic [1:0] op, int a, int b, int w);
    in_item_t it;
    it.op = op;
    it.vertex_a = VERTEX_W'(a);
    it.vertex_b = VERTEX_W'(b);
    it.edge_weight = WEIGHT_W'(w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(int nv, int c);
    settle();
    set_reg(REG_NUM_VERTICES, nv);
    set_reg(REG_MERGE_CONSTANT, c);
    cfg_valid <= 1'b0;
    active_n = nv;
    push_item(OP_CLEAR, 0, 0, 0);
  endtask

  task automatic random_block(int count, int c);
    int w;
    int pick;
    w = 0;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      w = w + $urandom_range(0, c / 12 + 1);
      if (w > 24'hFFFFFF) w = 24'hFFFFFF;
      if (pick < 70) begin
        push_item(OP_EDGE, $urandom_range(0, active_n - 1),
                  $urandom_range(0, active_n - 1), w);
      end else if (pick < 82) begin
        push_item(OP_FIND, $urandom_range(0, active_n - 1), $urandom_range(0, 65535),
                  $urandom_range(0, 24'hFFFFFF));
      end else if (pick < 88) begin
        push_item(OP_EDGE, $urandom_range(0, active_n - 1),
                  $urandom_range(0, active_n - 1), $urandom_range(0, 24'hFFFFFF));
      end else if (pick < 95 && active_n < 65536) begin
        if ($urandom_range(1)) begin
          push_item(OP_FIND, $urandom_range(active_n, 65535), 0, w);
        end else begin
          push_item(OP_EDGE, $urandom_range(0, 65535), $urandom_range(active_n, 65535), w);
        end
      end else if (pick < 97) begin
        push_item(OP_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535), w);
        w = 0;
      end else if (pick < 98) begin
        push_item(OP_RESERVED, $urandom_range(0, 65535), $urandom_range(0, 65535), w);
      end else begin
        push_item(OP_FIND, $urandom_range(0, active_n - 1), 0, 0);
      end
    end
  endtask

  initial begin
    int c;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(16, 76800);
    push_item(OP_EDGE, 0, 1, 0);
    push_item(OP_EDGE, 1, 0, 10);
    push_item(OP_EDGE, 2, 3, 24'hFFFFFF);
    push_item(OP_EDGE, 2, 0, 100);
    push_item(OP_EDGE, 4, 5, 200);
    push_item(OP_EDGE, 4, 0, 300);
    push_item(OP_FIND, 15, 65535, 24'hFFFFFF);
    push_item(OP_FIND, 16, 0, 0);
    push_item(OP_EDGE, 0, 16, 0);
    push_item(OP_EDGE, 65535, 0, 0);
    push_item(OP_RESERVED, 3, 7, 0);
    push_item(OP_FIND, 5, 0, 0);
    configure(4, 0);
    push_item(OP_EDGE, 0, 1, 0);
    push_item(OP_EDGE, 2, 3, 1);
    configure(2, 24'hFFFFFF);
    push_item(OP_EDGE, 1, 0, 24'hFFFFFF);
    configure(1, 76800);
    push_item(OP_FIND, 0, 0, 0);
    push_item(OP_EDGE, 0, 0, 0);
    push_item(OP_FIND, 1, 0, 0);
    configure(65536, 76800);
    push_item(OP_EDGE, 65535, 0, 5);
    push_item(OP_FIND, 65535, 0, 0);
    push_item(OP_EDGE, 32768, 65535, 6);

    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 83; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 83; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      for (int blk = 0; blk < 7; blk++) begin
        case ($urandom_range(9))
          0: c = 0;
          1: c = 24'hFFFFFF;
          2, 3: c = $urandom_range(0, 24'hFFFFFF);
          default: c = $urandom_range(1000, 200000);
        endcase
        configure($urandom_range(2, 64), c);
        random_block($urandom_range(22, 36), c);
      end
    end
    configure(65536, 24'hFFFFFF);
    random_block(30, 24'hFFFFFF);

    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
